[rtl/rps_pkg.sv]
`default_nettype none
package rps_pkg;

  // register index width and config data width
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // hold window must count more than this many pressed ticks
  localparam logic [7:0] HoldMinCount = 8'd5;

  // reset values of the configuration registers
  localparam logic [7:0]  DebounceTicksRst  = 8'd2;
  localparam logic [7:0]  HoldWindowRst     = 8'd10;
  localparam logic [15:0] AutooffTicksRst   = 16'd2000;
  localparam logic [7:0]  RadioIdleTicksRst = 8'd100;
  localparam logic [15:0] AdcPeriodRst      = 16'd10;
  localparam logic [11:0] BattLowLevelRst   = 12'd3000;
  localparam logic [11:0] BattHighLevelRst  = 12'd3400;

  // reset values of the supervisor state
  localparam logic [15:0] AdcWaitRst        = 16'd9;
  localparam logic [11:0] ReadingRst        = 12'd4095;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    RegDebounceTicks  = 3'd0,
    RegHoldWindow     = 3'd1,
    RegAutooffTicks   = 3'd2,
    RegRadioIdleTicks = 3'd3,
    RegAdcPeriod      = 3'd4,
    RegBattLowLevel   = 3'd5,
    RegBattHighLevel  = 3'd6
  } cfg_reg_e;

  // reason for a switch-off
  typedef enum logic [1:0] {
    CauseNone    = 2'd0,
    CauseIdle    = 2'd1,
    CauseBattLow = 2'd2,
    CauseButton  = 2'd3
  } off_cause_e;

  // input item, last declared field in the lowest bits
  typedef struct packed {
    logic        radio_send;
    logic [11:0] adc_value;
    logic        adc_done;
    logic        button_down;
    logic        press_event;
  } in_item_t;

  // result item, last declared field in the lowest bits, padded to whole bytes
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] sleep_ticks;
    logic        button_irq_enabled;
    logic        battery_ok;
    logic        adc_start;
    logic        radio_sleep_request;
    off_cause_e  off_cause;
    logic        sleep_request;
    logic        wake_request;
    logic        power_on;
  } out_item_t;

  localparam int unsigned InW  = $bits(in_item_t);
  localparam int unsigned OutW = $bits(out_item_t);

endpackage
`default_nettype wire

[rtl/remote_power_supervisor.sv]
// Power supervisor for a battery handheld, stepped once per slow tick.
// Each transaction on the slave stream is one tick: button edge and level,
// a finished battery conversion with its reading, and radio activity.
// Each tick yields exactly one result transaction on the master stream:
// supply state, wake/sleep pulses with the switch-off cause, radio sleep
// request, conversion start pulse, battery hysteresis state, button mask
// state and the saturating count of ticks since the last switch-off.
// The result sits in the output register from the cycle after the tick is
// taken. Throughput is one tick per cycle while the receiver keeps up; the
// whole update is one pass of counters and compares into the state and
// output registers. s_axis_tready stays high while the output register is
// empty or being drained, so a stalled receiver holds one result and stops
// new ticks only until it takes it.
// Configuration writes come over the cfg channel (index 0..6, unknown
// indexes are dropped), always ready; write only while no tick is in flight.
// Reset loads the register defaults, powers the supply off, unmasks the
// button, marks the battery good and empties the output register.
`default_nettype none
module remote_power_supervisor (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // tick stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // press_event, button_down, adc_done, adc_value[11:0], radio_send
  input  wire logic [rps_pkg::InW-1:0]      s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // power_on, wake_request, sleep_request, off_cause[1:0],
  // radio_sleep_request, adc_start, battery_ok, button_irq_enabled,
  // sleep_ticks[31:0], zero pad
  output logic [rps_pkg::OutW-1:0]          m_axis_tdata,
  // configuration writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [rps_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [rps_pkg::CfgDataW-1:0] cfg_data_i
);
  import rps_pkg::*;

  // configuration registers
  logic [7:0]  debounce_ticks_q, hold_window_q, radio_idle_ticks_q;
  logic [15:0] autooff_ticks_q, adc_period_q;
  logic [11:0] batt_low_q, batt_high_q;

  // supervisor state
  logic        supply_on_q, supply_on_d;
  logic [7:0]  hold_left_q, hold_left_d;
  logic [7:0]  hold_count_q, hold_count_d;
  logic [7:0]  debounce_left_q, debounce_left_d;
  logic        debounce_active_q, debounce_active_d;
  logic [15:0] idle_left_q, idle_left_d;
  logic [7:0]  radio_left_q, radio_left_d;
  logic [15:0] adc_wait_q, adc_wait_d;
  logic [11:0] latest_q, latest_d;
  logic [11:0] held_q, held_d;
  logic        batt_good_q, batt_good_d;
  logic [31:0] asleep_q, asleep_d;

  // output register
  logic        out_valid_q;
  out_item_t   out_q, out_d;

  in_item_t    in_item;
  logic        in_fire;
  logic        wake, sleep, radio_req, start;
  off_cause_e  cause, off;

  assign in_item       = in_item_t'(s_axis_tdata);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= DebounceTicksRst;
      hold_window_q      <= HoldWindowRst;
      autooff_ticks_q    <= AutooffTicksRst;
      radio_idle_ticks_q <= RadioIdleTicksRst;
      adc_period_q       <= AdcPeriodRst;
      batt_low_q         <= BattLowLevelRst;
      batt_high_q        <= BattHighLevelRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegDebounceTicks:  debounce_ticks_q   <= cfg_data_i[7:0];
        RegHoldWindow:     hold_window_q      <= cfg_data_i[7:0];
        RegAutooffTicks:   autooff_ticks_q    <= cfg_data_i;
        RegRadioIdleTicks: radio_idle_ticks_q <= cfg_data_i[7:0];
        RegAdcPeriod:      adc_period_q       <= cfg_data_i;
        RegBattLowLevel:   batt_low_q         <= cfg_data_i[11:0];
        RegBattHighLevel:  batt_high_q        <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // one tick of the supervisor
  always_comb begin
    supply_on_d       = supply_on_q;
    hold_left_d       = hold_left_q;
    hold_count_d      = hold_count_q;
    debounce_left_d   = debounce_left_q;
    debounce_active_d = debounce_active_q;
    idle_left_d       = idle_left_q;
    radio_left_d      = radio_left_q;
    adc_wait_d        = adc_wait_q;
    latest_d          = latest_q;
    held_d            = held_q;
    batt_good_d       = batt_good_q;
    wake              = 1'b0;
    sleep             = 1'b0;
    radio_req         = 1'b0;
    start             = 1'b0;
    cause             = CauseNone;
    off               = CauseNone;

    // accepted press opens the hold window and masks the button
    if (in_item.press_event && !debounce_active_q) begin
      debounce_left_d   = debounce_ticks_q;
      debounce_active_d = 1'b1;
      hold_left_d       = hold_window_q;
      hold_count_d      = '0;
    end
    if (in_item.adc_done) begin
      latest_d = in_item.adc_value;
    end
    if (in_item.radio_send) begin
      radio_left_d = radio_idle_ticks_q;
    end

    // hold window: count pressed ticks, toggle supply at the close
    if (hold_left_d != '0) begin
      if (in_item.button_down && hold_count_d != 8'hFF) begin
        hold_count_d = hold_count_d + 8'd1;
      end
      if (hold_left_d == 8'd1 && hold_count_d > HoldMinCount) begin
        if (supply_on_d) begin
          supply_on_d = 1'b0;
          sleep       = 1'b1;
          cause       = CauseButton;
        end else begin
          supply_on_d  = 1'b1;
          adc_wait_d   = adc_period_q;
          idle_left_d  = autooff_ticks_q;
          radio_left_d = radio_idle_ticks_q;
          wake         = 1'b1;
        end
        hold_count_d = '0;
      end
      hold_left_d = hold_left_d - 8'd1;
    end

    // debounce countdown, wraps when loaded with zero
    if (debounce_active_d) begin
      debounce_left_d = debounce_left_d - 8'd1;
      if (debounce_left_d == '0) begin
        debounce_active_d = 1'b0;
      end
    end

    // countdowns and battery check while powered
    if (supply_on_d) begin
      if (radio_left_d != '0) begin
        radio_left_d = radio_left_d - 8'd1;
        if (radio_left_d == '0) begin
          radio_req = 1'b1;
        end
      end
      if (idle_left_d != '0) begin
        idle_left_d = idle_left_d - 16'd1;
        if (idle_left_d == '0) begin
          off = CauseIdle;
        end
      end
      if (adc_wait_d == '0) begin
        adc_wait_d = adc_period_q;
        held_d     = latest_d;
        start      = 1'b1;
      end
      adc_wait_d = adc_wait_d - 16'd1;
      if (batt_good_d) begin
        if (held_d < batt_low_q) begin
          batt_good_d = 1'b0;
          idle_left_d = '0;
          off         = CauseBattLow;
        end
      end else if (held_d > batt_high_q) begin
        batt_good_d = 1'b1;
      end
      if (off != CauseNone) begin
        supply_on_d = 1'b0;
        sleep       = 1'b1;
        cause       = off;
      end
    end

    // saturating tick count since the last switch-off
    asleep_d = (asleep_q != 32'hFFFF_FFFF) ? asleep_q + 32'd1 : asleep_q;
    if (sleep) begin
      asleep_d = '0;
    end

    out_d.pad                 = '0;
    out_d.power_on            = supply_on_d;
    out_d.wake_request        = wake;
    out_d.sleep_request       = sleep;
    out_d.off_cause           = cause;
    out_d.radio_sleep_request = radio_req;
    out_d.adc_start           = start;
    out_d.battery_ok          = batt_good_d;
    out_d.button_irq_enabled  = !debounce_active_d;
    out_d.sleep_ticks         = asleep_d;
  end

  // state update on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_on_q       <= 1'b0;
      hold_left_q       <= '0;
      hold_count_q      <= '0;
      debounce_left_q   <= '0;
      debounce_active_q <= 1'b0;
      idle_left_q       <= '0;
      radio_left_q      <= RadioIdleTicksRst;
      adc_wait_q        <= AdcWaitRst;
      latest_q          <= ReadingRst;
      held_q            <= ReadingRst;
      batt_good_q       <= 1'b1;
      asleep_q          <= '0;
    end else if (in_fire) begin
      supply_on_q       <= supply_on_d;
      hold_left_q       <= hold_left_d;
      hold_count_q      <= hold_count_d;
      debounce_left_q   <= debounce_left_d;
      debounce_active_q <= debounce_active_d;
      idle_left_q       <= idle_left_d;
      radio_left_q      <= radio_left_d;
      adc_wait_q        <= adc_wait_d;
      latest_q          <= latest_d;
      held_q            <= held_d;
      batt_good_q       <= batt_good_d;
      asleep_q          <= asleep_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire
